// File: hdl/cnms_pkg.sv
`timescale 1ns / 1ps

package cnms_pkg;

    // Largest frame that the line memory can hold.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_SIZE   = 3;

    // Field and counter widths.
    localparam int GRAD_W = 11;
    localparam int CFG_W  = 11;
    localparam int SIZE_W = 11;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int MAG_W  = 22;
    localparam int SQ_W   = 21;
    localparam int SUMSQ_W = 24;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOW_THR = 2'd0;
    localparam logic [1:0] CFG_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_HEIGHT  = 2'd2;

    typedef enum logic [1:0] {
        BIN_N  = 2'd0,
        BIN_NE = 2'd1,
        BIN_E  = 2'd2,
        BIN_NW = 2'd3
    } t_bin;

    // One stored pixel: squared gradient magnitude and direction bin.
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        t_bin             bin;
    } t_pix;

    // One line memory entry: the pixel one row up and the pixel two rows up.
    typedef struct packed {
        t_pix near;
        t_pix far;
    } t_line_word;

    // Where the window center sits in the frame, and whether it yields a result.
    typedef struct packed {
        logic emit;
        logic up;
        logic down;
        logic left;
        logic right;
        logic frame_end;
    } t_pos;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] res;
        res = v;
        if (v < SIZE_W'(MIN_SIZE)) begin
            res = SIZE_W'(MIN_SIZE);
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

endpackage

// File: hdl/cnms_line_mem.sv
`timescale 1ns / 1ps

module cnms_line_mem (
    input  logic                                i_clk,
    input  logic                                i_rd_en,
    input  logic [cnms_pkg::COL_W-1:0]          i_rd_addr,
    output cnms_pkg::t_line_word                o_rd_data,
    input  logic                                i_wr_en,
    input  logic [cnms_pkg::COL_W-1:0]          i_wr_addr,
    input  cnms_pkg::t_line_word                i_wr_data
);

    // One entry per column, holding the two rows above the incoming pixel.
    cnms_pkg::t_line_word r_mem [cnms_pkg::MAX_WIDTH];
    cnms_pkg::t_line_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/canny_nonmax_suppression.sv
`timescale 1ns / 1ps
// Non-maximum suppression stage of a Canny edge detector.
// The input channel (i_valid / o_ready) takes one word per pixel in raster order:
// the Sobel gradients i_grad_x and i_grad_y, or a drain word with i_drain set.
// After the last pixel of a frame, frame_width + 1 drain words flush the last row.
// The output channel (o_valid / i_ready) gives one word per pixel: o_edge_res,
// o_direction and o_frame_end, which marks the frame's last pixel.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the low threshold,
// frame width and frame height; size changes take effect at the next frame start.
// Throughput is one word per clock unless stalled. The result for pixel p
// follows the acceptance of the word for pixel p + width + 1; that word
// completes the 3x3 neighborhood. The line memory has one read and one write
// port, read at the incoming column and written back shifted down from stage 2.
// When the receiver stalls, the output register holds its word and the pipeline
// freezes, so o_ready drops in the same cycle. Reset clears the counters,
// configuration (threshold 0, 640 x 480) and valid flags; the line memory is not
// cleared, because every entry is written in a frame before any result uses it.

module canny_nonmax_suppression (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [cnms_pkg::GRAD_W-1:0]    i_grad_x,
    input  logic signed [cnms_pkg::GRAD_W-1:0]    i_grad_y,
    input  logic                                  i_drain,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_edge_res,
    output logic [1:0]                            o_direction,
    output logic                                  o_frame_end,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [1:0]                            i_cfg_index,
    input  logic [cnms_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int COL_W  = cnms_pkg::COL_W;
    localparam int ROW_W  = cnms_pkg::ROW_W;
    localparam int SIZE_W = cnms_pkg::SIZE_W;
    localparam int GRAD_W = cnms_pkg::GRAD_W;
    localparam int MAG_W  = cnms_pkg::MAG_W;
    localparam int SQ_W   = cnms_pkg::SQ_W;
    localparam int SUMSQ_W = cnms_pkg::SUMSQ_W;

    // Configuration registers.
    logic [cnms_pkg::CFG_W-1:0] r_cfg_thr;
    logic [cnms_pkg::CFG_W-1:0] r_cfg_width;
    logic [cnms_pkg::CFG_W-1:0] r_cfg_height;
    logic [MAG_W-1:0]           r_lim;
    logic [MAG_W-1:0]           w_thr_ext;

    // Frame position of the next incoming word, and the latched frame size.
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [SIZE_W-1:0] r_frame_w, r_frame_h;
    logic [SIZE_W-1:0] w_w, w_h;
    logic              w_start, w_col_zero, w_flush, w_take, w_acc, w_en;
    cnms_pkg::t_pos    w_pos;

    // Stage 1: absolute gradients.
    logic                r1_valid;
    logic [GRAD_W-1:0]   r1_ax, r1_ay;
    logic                r1_same, r1_zero;
    logic [COL_W-1:0]    r1_col;
    cnms_pkg::t_pos      r1_pos;
    logic [GRAD_W-1:0]   w_ax, w_ay;

    // Stage 2: squares and the two rows above from the line memory.
    logic                  r2_valid;
    logic [SQ_W-1:0]       r2_sqx, r2_sqy;
    logic [SUMSQ_W-1:0]    r2_sqs;
    logic                  r2_same, r2_zero;
    logic [COL_W-1:0]      r2_col;
    cnms_pkg::t_pos        r2_pos;
    cnms_pkg::t_line_word  r2_rd;
    cnms_pkg::t_line_word  w_rd_data;
    logic [SQ_W-1:0]       w_axe, w_aye;
    logic [SUMSQ_W-1:0]    w_sume;

    // Stage 3: the new pixel enters the 3x3 window. Index 0 is the right
    // column, 1 the center column, 2 the left column.
    cnms_pkg::t_pix        w_new;
    cnms_pkg::t_line_word  w_wr_data;
    logic [MAG_W-1:0]      r_top [3];
    cnms_pkg::t_pix        r_mid [3];
    logic [MAG_W-1:0]      r_bot [3];
    logic                  r3_valid;
    cnms_pkg::t_pos        r3_pos;

    // Stage 4: output register.
    logic        r_out_valid;
    logic        r_out_edge;
    logic [1:0]  r_out_dir;
    logic        r_out_end;
    logic        w_sup, w_edge;
    logic [MAG_W-1:0] w_m;

    // ---------------------------------------------------------------
    // Handshakes. The whole pipeline moves together whenever the output
    // register is free or being emptied.
    // ---------------------------------------------------------------
    assign w_en        = !r_out_valid || i_ready;
    assign o_ready     = w_en;
    assign w_acc       = i_valid && w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_thr    <= '0;
            r_cfg_width  <= SIZE_W'(640);
            r_cfg_height <= SIZE_W'(480);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cnms_pkg::CFG_LOW_THR: r_cfg_thr    <= i_cfg_data;
                cnms_pkg::CFG_WIDTH:   r_cfg_width  <= i_cfg_data;
                cnms_pkg::CFG_HEIGHT:  r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The threshold is compared as a square against the squared magnitude.
    assign w_thr_ext = MAG_W'(r_cfg_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= '0;
        end else begin
            r_lim <= w_thr_ext * w_thr_ext;
        end
    end

    // ---------------------------------------------------------------
    // Frame position tracking.
    // ---------------------------------------------------------------
    assign w_start    = (r_col == '0) && (r_row == '0);
    assign w_col_zero = (r_col == '0);
    assign w_w = w_start ? cnms_pkg::clamp_size(r_cfg_width, SIZE_W'(cnms_pkg::MAX_WIDTH))
                         : r_frame_w;
    assign w_h = w_start ? cnms_pkg::clamp_size(r_cfg_height, SIZE_W'(cnms_pkg::MAX_HEIGHT))
                         : r_frame_h;

    // Past the last pixel every word counts as a drain word; a drain word
    // before that point is dropped without effect.
    assign w_flush = (SIZE_W'(r_row) >= w_h);
    assign w_take  = w_acc && !(i_drain && !w_flush);

    // The window center trails the incoming word by one row and one column.
    always_comb begin
        if (w_col_zero) begin
            w_pos.emit      = (r_row >= ROW_W'(2));
            w_pos.up        = (r_row >= ROW_W'(3));
            w_pos.down      = (SIZE_W'(r_row) <= w_h);
            w_pos.left      = 1'b1;
            w_pos.right     = 1'b0;
            w_pos.frame_end = ({1'b0, SIZE_W'(r_row)} == ({1'b0, w_h} + (SIZE_W + 1)'(1)));
        end else begin
            w_pos.emit      = (r_row >= ROW_W'(1));
            w_pos.up        = (r_row >= ROW_W'(2));
            w_pos.down      = (SIZE_W'(r_row) < w_h);
            w_pos.left      = (r_col >= COL_W'(2));
            w_pos.right     = 1'b1;
            w_pos.frame_end = 1'b0;
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_pos.frame_end) begin
            n_col = '0;
            n_row = '0;
        end else if ({1'b0, r_col} == (w_w - SIZE_W'(1))) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_frame_w <= '0;
            r_frame_h <= '0;
        end else if (w_take) begin
            r_col <= n_col;
            r_row <= n_row;
            if (w_start) begin
                r_frame_w <= w_w;
                r_frame_h <= w_h;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1.
    // ---------------------------------------------------------------
    assign w_ax = i_grad_x[GRAD_W-1] ? GRAD_W'(~i_grad_x + GRAD_W'(1)) : i_grad_x;
    assign w_ay = i_grad_y[GRAD_W-1] ? GRAD_W'(~i_grad_y + GRAD_W'(1)) : i_grad_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ax   <= w_ax;
            r1_ay   <= w_ay;
            r1_same <= (i_grad_x[GRAD_W-1] == i_grad_y[GRAD_W-1]);
            r1_zero <= (w_ax == '0) && (w_ay == '0);
            r1_col  <= r_col;
            r1_pos  <= w_pos;
        end
    end

    // The line memory is read at the incoming column and written back at the
    // same column from stage 2. A frame is at least three columns wide, so
    // no read of a column can fall between its read and write.
    cnms_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_take),
        .i_rd_addr (r_col),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_en && r2_valid),
        .i_wr_addr (r2_col),
        .i_wr_data (w_wr_data)
    );

    // ---------------------------------------------------------------
    // Stage 2.
    // ---------------------------------------------------------------
    assign w_axe  = SQ_W'(r1_ax);
    assign w_aye  = SQ_W'(r1_ay);
    assign w_sume = SUMSQ_W'(r1_ax) + SUMSQ_W'(r1_ay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_sqx  <= w_axe * w_axe;
            r2_sqy  <= w_aye * w_aye;
            r2_sqs  <= w_sume * w_sume;
            r2_same <= r1_same;
            r2_zero <= r1_zero;
            r2_col  <= r1_col;
            r2_pos  <= r1_pos;
            r2_rd   <= w_rd_data;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: magnitude and direction bin of the new pixel. The bin is
    // decided exactly on squares: (|gx|+|gy|)^2 against 2|gx|^2 and 2|gy|^2.
    // ---------------------------------------------------------------
    always_comb begin
        w_new.mag = MAG_W'(r2_sqx) + MAG_W'(r2_sqy);
        priority if (r2_zero) begin
            w_new.bin = cnms_pkg::BIN_E;
        end else if (r2_sqs < SUMSQ_W'({r2_sqx, 1'b0})) begin
            w_new.bin = cnms_pkg::BIN_E;
        end else if (r2_sqs < SUMSQ_W'({r2_sqy, 1'b0})) begin
            w_new.bin = cnms_pkg::BIN_N;
        end else if (r2_same) begin
            w_new.bin = cnms_pkg::BIN_NE;
        end else begin
            w_new.bin = cnms_pkg::BIN_NW;
        end
    end

    // The column shifts down one row: the new pixel becomes the near row.
    assign w_wr_data.near = w_new;
    assign w_wr_data.far  = r2_rd.near;

    always_ff @(posedge i_clk) begin
        if (w_en && r2_valid) begin
            r_top[2] <= r_top[1];
            r_top[1] <= r_top[0];
            r_top[0] <= r2_rd.far.mag;
            r_mid[2] <= r_mid[1];
            r_mid[1] <= r_mid[0];
            r_mid[0] <= r2_rd.near;
            r_bot[2] <= r_bot[1];
            r_bot[1] <= r_bot[0];
            r_bot[0] <= w_new.mag;
            r3_pos   <= r2_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid && r2_pos.emit;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: suppression along the gradient direction. Neighbors outside
    // the frame take no part.
    // ---------------------------------------------------------------
    assign w_m = r_mid[1].mag;

    always_comb begin
        unique case (r_mid[1].bin)
            cnms_pkg::BIN_N: begin
                w_sup = (r3_pos.up && (r_top[1] > w_m)) ||
                        (r3_pos.down && (r_bot[1] > w_m));
            end
            cnms_pkg::BIN_NE: begin
                w_sup = (r3_pos.up && r3_pos.right && (r_top[0] > w_m)) ||
                        (r3_pos.down && r3_pos.left && (r_bot[2] > w_m));
            end
            cnms_pkg::BIN_E: begin
                w_sup = (r3_pos.right && (r_mid[0].mag > w_m)) ||
                        (r3_pos.left && (r_mid[2].mag > w_m));
            end
            cnms_pkg::BIN_NW: begin
                w_sup = (r3_pos.up && r3_pos.left && (r_top[2] > w_m)) ||
                        (r3_pos.down && r3_pos.right && (r_bot[0] > w_m));
            end
            default: w_sup = 1'b0;
        endcase
    end

    assign w_edge = (w_m >= r_lim) && !w_sup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_edge <= w_edge;
            r_out_dir  <= r_mid[1].bin;
            r_out_end  <= r3_pos.frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_edge_res  = r_out_edge;
    assign o_direction = r_out_dir;
    assign o_frame_end = r_out_end;

endmodule

// File: tb/sv/tb_canny_nonmax_suppression.sv
`timescale 1ns / 1ps

// Self-checking bench for the Canny non-maximum suppression stage.
//
// The bench drives the pixel channel and the configuration channel with
// valid/ready handshakes and takes result words from the output channel.
// Every accepted input word goes through an in-bench predictor. The predictor
// keeps its own line memory of squared magnitudes and direction bins. It also
// keeps its own frame position and its own copy of the registers. Its words
// are queued unless a directed row says otherwise. Each result word taken
// from the block must match the oldest queued word, field by field.
//
// Stimulus comes in two parts. A short directed table is walked first. It
// covers a drain word straight out of reset, frame sizes that must be clamped,
// both threshold extremes, every direction bin, the most negative gradient,
// a drain in the middle of a frame and a pixel word inside the flush. After
// that come random phases. Each phase writes all three registers and then
// plays one or more frames. Frames are mostly small and well formed. A few
// stray drains and pixel words inside the flush are mixed in. Two phases use
// the widest and the tallest frame the line memory supports.

module tb_canny_nonmax_suppression;

    import cnms_pkg::*;

    localparam int LINE_DEPTH   = 2 * MAX_WIDTH + 3;
    localparam int RANDOM_ITEMS = 1450;
    // Cycles to let pass once the last expected word is in. A taken word that
    // releases no result still travels down the four-stage pipeline.
    localparam int QUIET_CYCLES = 16;

    // One result word as the block presents it.
    typedef struct packed {
        logic edge_res;
        t_bin dir;
        logic frame_end;
    } nms_word_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PIX,
        ROW_DRAIN
    } row_kind_t;

    // How a directed row is checked. Most rows use the predictor. Some rows
    // are known to give no word. Others carry a result that can be typed in.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_GIVEN
    } row_check_t;

    // a and b are the gradients of a pixel row, or the register index and the
    // write data of a configuration row.
    typedef struct packed {
        row_kind_t   kind;
        logic [10:0] a;
        logic [10:0] b;
        row_check_t  check;
        nms_word_t   word;
    } stim_row_t;

    // Gradient content of a random frame.
    typedef enum logic [1:0] {
        FILL_WIDE,
        FILL_NARROW,
        FILL_SPARSE
    } fill_t;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic                     o_ready;
    logic signed [GRAD_W-1:0] i_grad_x    = '0;
    logic signed [GRAD_W-1:0] i_grad_y    = '0;
    logic                     i_drain     = 1'b0;
    logic                     o_valid;
    logic                     i_ready     = 1'b0;
    logic                     o_edge_res;
    logic [1:0]               o_direction;
    logic                     o_frame_end;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [1:0]               i_cfg_index = '0;
    logic [CFG_W-1:0]         i_cfg_data  = '0;

    canny_nonmax_suppression u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_grad_x    (i_grad_x),
        .i_grad_y    (i_grad_y),
        .i_drain     (i_drain),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_edge_res  (o_edge_res),
        .o_direction (o_direction),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The bench's copy of the registers. The values match the block's reset.
    logic [10:0] thr_reg    = 11'd0;
    logic [10:0] width_reg  = 11'd640;
    logic [10:0] height_reg = 11'd480;

    // The predictor's frame state. The frame size is latched at the first
    // pixel of each frame.
    int unsigned frame_pos = 0;
    int unsigned frame_w   = 0;
    int unsigned frame_h   = 0;
    bit [21:0]   mag_mem [LINE_DEPTH];
    t_bin        bin_mem [LINE_DEPTH];

    nms_word_t   awaited_words [$];
    stim_row_t   plan [$];
    int          mismatches    = 0;
    int          counted_items = 0;
    int          in_gap_pct    = 25;
    int          out_gap_pct   = 25;

    function automatic int unsigned fit_size(input logic [10:0] v, input int unsigned hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned mag_at(input int unsigned idx);
        return mag_mem[idx % LINE_DEPTH];
    endfunction

    // Predicts what the block does with one accepted input word. The return
    // value is 1 when the word releases a result, and res then holds it. The
    // result released is always for the pixel one row and one column behind.
    function automatic bit predict_word(input logic signed [10:0] gx,
                                        input logic signed [10:0] gy,
                                        input logic dr, output nms_word_t res);
        int          sx, sy, ax, ay, sq;
        int unsigned n, total, p, r, c, m, lim, thr;
        t_bin        b;
        bit          up, down, left, right, sup;
        res = '0;
        if (frame_pos == 0) begin
            // A drain word between frames is ignored and leaves the size unlatched.
            if (dr) return 1'b0;
            frame_w = fit_size(width_reg, MAX_WIDTH);
            frame_h = fit_size(height_reg, MAX_HEIGHT);
        end
        total = frame_w * frame_h;
        n = frame_pos;
        if (n < total) begin
            // A drain word before the frame is complete does nothing at all.
            if (dr) return 1'b0;
            sx = gx;
            sy = gy;
            ax = (sx < 0) ? -sx : sx;
            ay = (sy < 0) ? -sy : sy;
            sq = (ax + ay) * (ax + ay);
            // Integer tests against tan(22.5) and tan(67.5). A zero gradient
            // counts as east.
            if (ax == 0 && ay == 0) b = BIN_E;
            else if (sq < 2 * ax * ax) b = BIN_E;
            else if (sq < 2 * ay * ay) b = BIN_N;
            else if ((sx < 0) == (sy < 0)) b = BIN_NE;
            else b = BIN_NW;
            mag_mem[n % LINE_DEPTH] = 22'(sx * sx + sy * sy);
            bin_mem[n % LINE_DEPTH] = b;
        end
        // From here on, a pixel word during the flush acts as a drain.
        frame_pos = n + 1;
        if (n < frame_w + 1) return 1'b0;

        p = n - frame_w - 1;
        r = p / frame_w;
        c = p % frame_w;
        m = mag_at(p);
        b = bin_mem[p % LINE_DEPTH];
        thr = thr_reg;
        lim = thr * thr;
        up = (r > 0);
        down = (r + 1 < frame_h);
        left = (c > 0);
        right = (c + 1 < frame_w);
        // Only neighbours inside the frame count, and only a strictly larger
        // magnitude suppresses.
        case (b)
            BIN_N:
                sup = (up && mag_at(p - frame_w) > m) || (down && mag_at(p + frame_w) > m);
            BIN_NE:
                sup = (up && right && mag_at(p - frame_w + 1) > m) ||
                      (down && left && mag_at(p + frame_w - 1) > m);
            BIN_E:
                sup = (right && mag_at(p + 1) > m) || (left && mag_at(p - 1) > m);
            default:
                sup = (up && left && mag_at(p - frame_w - 1) > m) ||
                      (down && right && mag_at(p + frame_w + 1) > m);
        endcase
        res.edge_res = (m >= lim) && !sup;
        res.dir = b;
        res.frame_end = (p + 1 == total);
        if (res.frame_end) frame_pos = 0;
        return 1'b1;
    endfunction

    function automatic logic [10:0] pick_grad(input fill_t fill);
        int v;
        case (fill)
            FILL_WIDE: begin
                if ($urandom_range(63) == 0) v = -1024;
                else v = int'($urandom_range(2040)) - 1020;
            end
            FILL_NARROW: begin
                // Small values give many equal magnitudes side by side.
                v = int'($urandom_range(8)) - 4;
            end
            default: begin
                case ($urandom_range(7))
                    0: v = -1024;
                    1: v = -1020;
                    2: v = -512;
                    3: v = -1;
                    4: v = 0;
                    5: v = 1;
                    6: v = 511;
                    default: v = 1020;
                endcase
            end
        endcase
        return 11'(v);
    endfunction

    // Presents one pixel or drain word and holds it until it is accepted. The
    // predictor then runs on the word, at the edge where it was accepted.
    task automatic send_pixel(input logic signed [10:0] gx, input logic signed [10:0] gy,
                              input logic dr, input row_check_t check,
                              input nms_word_t given);
        nms_word_t w;
        bit        has;
        while ($urandom_range(99) < in_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_grad_x <= gx;
        i_grad_y <= gy;
        i_drain  <= dr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        has = predict_word(gx, gy, dr, w);
        if (check == CHK_MODEL && has) awaited_words.push_back(w);
        else if (check == CHK_GIVEN) awaited_words.push_back(given);
    endtask

    // Writes one register. The caller lowers i_cfg_valid after the last write
    // of a group, so back-to-back writes keep valid high.
    task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
        while ($urandom_range(99) < in_gap_pct) begin
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_LOW_THR: thr_reg = val;
            CFG_WIDTH:   width_reg = val;
            CFG_HEIGHT:  height_reg = val;
            default: ;
        endcase
    endtask

    // Stops the pixel stream and waits until every predicted word has come
    // out. It then waits a few more cycles for words still in the pipeline
    // that release no result.
    task automatic settle_idle();
        i_valid <= 1'b0;
        while (awaited_words.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // One well-formed frame: W*H pixels, then W+1 flush words. Now and then
    // a stray drain comes before the frame or in its middle. Some flush
    // words are pixel words, which the block must treat as drains.
    task automatic play_frame(input fill_t fill, input bit counted);
        int unsigned fw, fh;
        fw = fit_size(width_reg, MAX_WIDTH);
        fh = fit_size(height_reg, MAX_HEIGHT);
        if ($urandom_range(4) == 0)
            send_pixel(pick_grad(FILL_WIDE), pick_grad(FILL_WIDE), 1'b1, CHK_MODEL, '0);
        for (int unsigned k = 0; k < fw * fh; k++) begin
            if ($urandom_range(31) == 0)
                send_pixel(pick_grad(FILL_WIDE), pick_grad(FILL_WIDE), 1'b1, CHK_MODEL, '0);
            send_pixel(pick_grad(fill), pick_grad(fill), 1'b0, CHK_MODEL, '0);
        end
        for (int unsigned k = 0; k <= fw; k++)
            send_pixel(pick_grad(fill), pick_grad(fill), $urandom_range(3) != 0, CHK_MODEL, '0);
        if (counted) counted_items += fw * fh + fw + 1;
    endtask

    // The output side. i_ready drops at random. Every word taken is checked
    // against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        nms_word_t want;
        i_ready <= ($urandom_range(99) >= out_gap_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: edge %0b dir %0d end %0b",
                             o_edge_res, o_direction, o_frame_end);
            end else begin
                want = awaited_words.pop_front();
                if (o_edge_res !== want.edge_res || o_direction !== want.dir ||
                    o_frame_end !== want.frame_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected edge %0b dir %0d end %0b, got edge %0b dir %0d end %0b",
                                 want.edge_res, want.dir, want.frame_end,
                                 o_edge_res, o_direction, o_frame_end);
                end
            end
        end
    end

    initial begin : stimulus
        bit          cfg_open;
        int          phase;
        fill_t       fill;
        int          nframes;
        logic [10:0] thr_val, w_val, h_val;

        // Right after reset, a drain is ignored. Then comes a 3x3 frame at
        // threshold 0, with the size written as 0 by 1 so that both get
        // clamped. Its first W+1 words give nothing.
        plan.push_back('{ROW_DRAIN, 11'd0, 11'd0, CHK_NONE, '0});
        plan.push_back('{ROW_CFG, 11'(CFG_LOW_THR), 11'd0, CHK_NONE, '0});
        plan.push_back('{ROW_CFG, 11'(CFG_WIDTH), 11'd0, CHK_NONE, '0});
        plan.push_back('{ROW_CFG, 11'(CFG_HEIGHT), 11'd1, CHK_NONE, '0});
        plan.push_back('{ROW_PIX, 11'h400, 11'd0, CHK_NONE, '0});       // -1024
        plan.push_back('{ROW_PIX, 11'sd1020, 11'sd1020, CHK_NONE, '0}); // north-east
        plan.push_back('{ROW_DRAIN, 11'd5, 11'd9, CHK_NONE, '0});       // mid-frame drain
        plan.push_back('{ROW_PIX, 11'd0, 11'd0, CHK_NONE, '0});         // zero, east
        plan.push_back('{ROW_PIX, -11'sd1020, 11'sd1020, CHK_NONE, '0});// north-west
        plan.push_back('{ROW_PIX, 11'd0, -11'sd1020, CHK_MODEL, '0});   // north
        plan.push_back('{ROW_PIX, 11'sd1020, -11'sd3, CHK_MODEL, '0});
        plan.push_back('{ROW_PIX, 11'sd3, 11'sd4, CHK_MODEL, '0});
        plan.push_back('{ROW_PIX, -11'sd7, -11'sd700, CHK_MODEL, '0});
        plan.push_back('{ROW_PIX, 11'sd300, -11'sd200, CHK_MODEL, '0});
        plan.push_back('{ROW_DRAIN, 11'd0, 11'd0, CHK_MODEL, '0});
        plan.push_back('{ROW_PIX, 11'sd511, -11'sd512, CHK_MODEL, '0}); // pixel in the flush
        plan.push_back('{ROW_DRAIN, 11'd0, 11'd0, CHK_MODEL, '0});
        plan.push_back('{ROW_DRAIN, 11'd0, 11'd0, CHK_MODEL, '0});
        // At the largest threshold, no gradient below +-1020 can reach it.
        // With all bins east, each word reads off directly.
        plan.push_back('{ROW_CFG, 11'(CFG_LOW_THR), 11'd1443, CHK_NONE, '0});
        plan.push_back('{ROW_CFG, 11'(CFG_WIDTH), 11'd3, CHK_NONE, '0});
        plan.push_back('{ROW_CFG, 11'(CFG_HEIGHT), 11'd3, CHK_NONE, '0});
        plan.push_back('{ROW_PIX, 11'sd1020, 11'd0, CHK_NONE, '0});
        plan.push_back('{ROW_PIX, -11'sd1020, 11'd0, CHK_NONE, '0});
        plan.push_back('{ROW_PIX, 11'sd1, 11'd0, CHK_NONE, '0});
        plan.push_back('{ROW_PIX, 11'sd1020, -11'sd1, CHK_NONE, '0});
        plan.push_back('{ROW_PIX, -11'sd1, 11'd0, CHK_GIVEN, '{1'b0, BIN_E, 1'b0}});
        plan.push_back('{ROW_PIX, 11'sd7, 11'sd2, CHK_GIVEN, '{1'b0, BIN_E, 1'b0}});
        plan.push_back('{ROW_PIX, 11'sd1000, -11'sd3, CHK_GIVEN, '{1'b0, BIN_E, 1'b0}});
        plan.push_back('{ROW_PIX, 11'sd512, 11'd0, CHK_GIVEN, '{1'b0, BIN_E, 1'b0}});
        plan.push_back('{ROW_PIX, -11'sd1020, 11'sd400, CHK_GIVEN, '{1'b0, BIN_E, 1'b0}});
        plan.push_back('{ROW_DRAIN, 11'd0, 11'd0, CHK_GIVEN, '{1'b0, BIN_E, 1'b0}});
        plan.push_back('{ROW_DRAIN, 11'd0, 11'd0, CHK_GIVEN, '{1'b0, BIN_E, 1'b0}});
        plan.push_back('{ROW_DRAIN, 11'd0, 11'd0, CHK_GIVEN, '{1'b0, BIN_E, 1'b0}});
        plan.push_back('{ROW_DRAIN, 11'd0, 11'd0, CHK_GIVEN, '{1'b0, BIN_E, 1'b1}});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers are only written with the pipeline empty. The first write
        // of a group therefore waits for all outstanding words.
        cfg_open = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                if (!cfg_open) settle_idle();
                cfg_open = 1'b1;
                write_reg(plan[i].a[1:0], plan[i].b);
            end else begin
                if (cfg_open) i_cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                send_pixel(plan[i].a, plan[i].b, plan[i].kind == ROW_DRAIN,
                           plan[i].check, plan[i].word);
            end
        end

        // Random phases. Every fourth phase runs with no idling on either
        // side. Phase 2 uses the widest frame, reached by writing an
        // oversized width. Phase 5 uses the tallest frame.
        phase = 0;
        while (counted_items < RANDOM_ITEMS || phase <= 5) begin
            fill = fill_t'($urandom_range(2));
            in_gap_pct = (phase % 4 == 3) ? 0 : 25;
            out_gap_pct = in_gap_pct;
            if (phase == 2) begin
                w_val = 11'd2047;
                h_val = 11'd0;
                nframes = 1;
            end else if (phase == 5) begin
                w_val = 11'd3;
                h_val = 11'd1500;
                nframes = 1;
            end else begin
                w_val = ($urandom_range(7) == 0) ? 11'($urandom_range(2))
                                                 : 11'($urandom_range(12, 3));
                h_val = ($urandom_range(7) == 0) ? 11'($urandom_range(2))
                                                 : 11'($urandom_range(12, 3));
                nframes = $urandom_range(3, 1);
            end
            case ($urandom_range(3))
                0: thr_val = 11'd0;
                1: thr_val = 11'd1443;
                default: begin
                    // Keep narrow frames near their magnitudes, so the
                    // threshold actually cuts.
                    thr_val = (fill == FILL_NARROW) ? 11'($urandom_range(6))
                                                    : 11'($urandom_range(1443));
                end
            endcase
            settle_idle();
            write_reg(CFG_LOW_THR, thr_val);
            write_reg(CFG_WIDTH, w_val);
            write_reg(CFG_HEIGHT, h_val);
            i_cfg_valid <= 1'b0;
            repeat (nframes) play_frame(fill, phase != 2 && phase != 5);
            phase++;
        end

        settle_idle();
        if (mismatches == 0 && awaited_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin : watchdog
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
